// ===== rtl/adpcm_nibble_decoder_defines.svh =====
// ============================================================================
// adpcm_nibble_decoder_defines.svh
// Assertion macros used by the ADPCM nibble decoder RTL.
// ============================================================================
`ifndef ADPCM_NIBBLE_DECODER_DEFINES_SVH
`define ADPCM_NIBBLE_DECODER_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define ADN_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define ADN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/adn_pkg.sv =====
// ============================================================================
// adn_pkg
// Types, constants and the step-size table of the ADPCM nibble decoder.
// ============================================================================
package adn_pkg;

    localparam int PRED_W  = 12;
    localparam int STEP_W  = 6;
    localparam int CODE_W  = 4;
    localparam int SIZE_W  = 11;   // largest step size is 1552
    localparam int SUM_W   = PRED_W + 2;

    localparam logic [STEP_W-1:0] STEP_MAX = STEP_W'(48);
    localparam logic signed [SUM_W-1:0] PRED_MAX = SUM_W'(2047);
    localparam logic signed [SUM_W-1:0] PRED_MIN = -SUM_W'(2048);

    // Input item kinds (tuser)
    localparam logic ACT_LATCH = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    // Decoder state carried between the register file and the step unit
    typedef struct packed {
        logic signed [PRED_W-1:0] pred;
        logic [STEP_W-1:0]        step;
    } t_dec_state;

    // Step size, floor(16 * 1.1^idx); indexes past the top read the last entry
    function automatic logic [SIZE_W-1:0] step_size(input logic [STEP_W-1:0] idx);
        logic [SIZE_W-1:0] s;
        case (idx)
            6'd0:  s = 11'd16;   6'd1:  s = 11'd17;   6'd2:  s = 11'd19;
            6'd3:  s = 11'd21;   6'd4:  s = 11'd23;   6'd5:  s = 11'd25;
            6'd6:  s = 11'd28;   6'd7:  s = 11'd31;   6'd8:  s = 11'd34;
            6'd9:  s = 11'd37;   6'd10: s = 11'd41;   6'd11: s = 11'd45;
            6'd12: s = 11'd50;   6'd13: s = 11'd55;   6'd14: s = 11'd60;
            6'd15: s = 11'd66;   6'd16: s = 11'd73;   6'd17: s = 11'd80;
            6'd18: s = 11'd88;   6'd19: s = 11'd97;   6'd20: s = 11'd107;
            6'd21: s = 11'd118;  6'd22: s = 11'd130;  6'd23: s = 11'd143;
            6'd24: s = 11'd157;  6'd25: s = 11'd173;  6'd26: s = 11'd190;
            6'd27: s = 11'd209;  6'd28: s = 11'd230;  6'd29: s = 11'd253;
            6'd30: s = 11'd279;  6'd31: s = 11'd307;  6'd32: s = 11'd337;
            6'd33: s = 11'd371;  6'd34: s = 11'd408;  6'd35: s = 11'd449;
            6'd36: s = 11'd494;  6'd37: s = 11'd544;  6'd38: s = 11'd598;
            6'd39: s = 11'd658;  6'd40: s = 11'd724;  6'd41: s = 11'd796;
            6'd42: s = 11'd876;  6'd43: s = 11'd963;  6'd44: s = 11'd1060;
            6'd45: s = 11'd1166; 6'd46: s = 11'd1282; 6'd47: s = 11'd1411;
            default: s = 11'd1552;
        endcase
        return s;
    endfunction

    // Step index adjustment from the low three code bits
    function automatic logic signed [4:0] index_move(input logic [2:0] mag_bits);
        logic signed [4:0] m;
        case (mag_bits)
            3'd4:    m = 5'sd2;
            3'd5:    m = 5'sd4;
            3'd6:    m = 5'sd6;
            3'd7:    m = 5'sd8;
            default: m = -5'sd1;
        endcase
        return m;
    endfunction

endpackage

// ===== rtl/adn_step_unit.sv =====
// ============================================================================
// adn_step_unit
// One decode step: table lookup, predictor add with clamp, step index update.
// ============================================================================
module adn_step_unit
    import adn_pkg::*;
(
    input  t_dec_state         i_cur,
    input  logic [CODE_W-1:0]  i_code,
    output t_dec_state         o_nxt
);

    logic [SIZE_W-1:0]        s;
    logic [PRED_W-1:0]        mag;
    logic signed [SUM_W-1:0]  sum;
    logic signed [STEP_W:0]   idx;
    logic signed [PRED_W-1:0] pred_nxt;
    logic [STEP_W-1:0]        step_nxt;

    // Difference magnitude from the shifted step size
    always_comb begin
        s   = step_size(i_cur.step);
        mag = PRED_W'(s >> 3);
        if (i_code[2]) begin
            mag = mag + PRED_W'(s);
        end
        if (i_code[1]) begin
            mag = mag + PRED_W'(s >> 1);
        end
        if (i_code[0]) begin
            mag = mag + PRED_W'(s >> 2);
        end
    end

    // Predictor add and clamp to 12 bits
    always_comb begin
        if (i_code[3]) begin
            sum = SUM_W'(i_cur.pred) - $signed({2'b00, mag});
        end else begin
            sum = SUM_W'(i_cur.pred) + $signed({2'b00, mag});
        end
        if (sum > PRED_MAX) begin
            pred_nxt = PRED_MAX[PRED_W-1:0];
        end else if (sum < PRED_MIN) begin
            pred_nxt = PRED_MIN[PRED_W-1:0];
        end else begin
            pred_nxt = sum[PRED_W-1:0];
        end
    end

    // Step index move and clamp to 0..48
    always_comb begin
        idx = $signed({1'b0, i_cur.step}) + (STEP_W+1)'(index_move(i_code[2:0]));
        if (idx < 0) begin
            step_nxt = '0;
        end else if (idx > $signed({1'b0, STEP_MAX})) begin
            step_nxt = STEP_MAX;
        end else begin
            step_nxt = idx[STEP_W-1:0];
        end
    end

    assign o_nxt = '{pred: pred_nxt, step: step_nxt};

endmodule

// ===== rtl/adpcm_nibble_decoder.sv =====
// ============================================================================
// adpcm_nibble_decoder
// OKI-style 4-bit ADPCM decoder with a streaming input and output.
// ============================================================================
// Usage:
//   Slave channel: one transaction per item. tuser is the kind (0 = latch the
//   code nibble, 1 = decode tick); tdata carries the code and the reset pin.
//   Master channel: one transaction per input item, carrying the predictor
//   as it stands after that item (12-bit two's complement in tdata[11:0]).
//   Configuration: i_cfg_wr_en writes four_bit_mode from i_cfg_wr_data; the
//   mode is applied when a code is latched, so write it only while idle.
// Pipeline and throughput:
//   An input item passes the input register, then the result register. One item
//   per cycle sustained while the master accepts; the decoder state loop is
//   step-size lookup, predictor add and clamp, and step index update in adn_step_unit.
// Reset:
//   Synchronous, active low. Clears predictor, step index, latched code, mode
//   and both valid flags.
// Stalls:
//   With the result register full and the master stalled, one more item waits
//   in the input register; then s_axis_tready drops until the result is taken.
// ============================================================================
`include "adpcm_nibble_decoder_defines.svh"

module adpcm_nibble_decoder
    import adn_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [3:0] code_nibble, [4] hold_reset, [7:5] zero
    input  logic [0:0]  s_axis_tuser,   // [0] action
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [11:0] pcm_sample, [15:12] sign fill zero
);

    logic                     r_mode;
    logic                     r_in_valid;
    logic                     r_in_action;
    logic                     r_in_hold;
    logic [CODE_W-1:0]        r_in_code;
    logic                     r_out_valid;
    logic signed [PRED_W-1:0] r_out_pcm;
    t_dec_state               r_state;
    t_dec_state               n_state;
    logic [CODE_W-1:0]        r_code;
    logic [CODE_W-1:0]        n_code;
    t_dec_state               step_nxt;
    logic                     out_free;
    logic                     advance;
    logic                     in_take;

    // Handshake: input register refills whenever its item moves on
    assign out_free      = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_mode <= i_cfg_wr_data;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_action <= s_axis_tuser[0];
            r_in_code   <= s_axis_tdata[3:0];
            r_in_hold   <= s_axis_tdata[4];
        end
    end

    adn_step_unit u_step (
        .i_cur  (r_state),
        .i_code (r_code),
        .o_nxt  (step_nxt)
    );

    // Next decoder state for the item in the input register
    always_comb begin
        n_state = r_state;
        n_code  = r_code;
        if (r_in_action == ACT_LATCH) begin
            n_code = r_mode ? r_in_code : {r_in_code[2:0], 1'b0};
        end else if (r_in_hold) begin
            n_state = '0;
        end else begin
            n_state = step_nxt;
        end
    end

    // Decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
            r_code  <= '0;
        end else if (advance) begin
            r_state <= n_state;
            r_code  <= n_code;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_pcm <= n_state.pred;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out_pcm};

    // Checks
    `ADN_ASSERT_NOW(a_step_range, i_clk, i_rst_n, 1'b1, r_state.step <= STEP_MAX, "step index out of range")
    `ADN_ASSERT_NOW(a_out_matches_pred, i_clk, i_rst_n, r_out_valid, r_out_pcm == r_state.pred, "result differs from predictor")
    `ADN_ASSERT_NEXT(a_hold_clears, i_clk, i_rst_n, advance && r_in_action == ACT_TICK && r_in_hold, r_state.pred == '0 && r_state.step == '0, "hold tick did not clear state")
    `ADN_ASSERT_NOW(a_stall_only_full, i_clk, i_rst_n, !s_axis_tready, r_in_valid && r_out_valid, "input stalled with free stage")

endmodule
